// ===== rtl/mptm_pkg.sv =====
package mptm_pkg;

  // Field widths of the request and result items
  localparam int MacW      = 48;
  localparam int SlotW     = 6;
  localparam int PrefixW   = 36;
  localparam int LenW      = 2;
  localparam int CatW      = 4;
  localparam int SpecW     = 2;
  localparam int CountW    = 7;
  localparam int MatchIdxW = 6;

  // Packed stream widths, rounded up to whole bytes
  localparam int InFieldsW  = MacW + SlotW + PrefixW + LenW + CatW + SpecW;
  localparam int InDataW    = ((InFieldsW + 7) / 8) * 8;
  localparam int OutFieldsW = 1 + MatchIdxW + CatW + SpecW;
  localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // Request kinds carried on tuser
  typedef enum logic {
    KIND_LOOKUP = 1'b0,
    KIND_LOAD   = 1'b1
  } kind_e;

  // Prefix length codes
  typedef enum logic [LenW-1:0] {
    LEN_24   = 2'd0,
    LEN_28   = 2'd1,
    LEN_36   = 2'd2,
    LEN_NONE = 2'd3
  } len_e;

  // One table entry
  typedef struct packed {
    logic [PrefixW-1:0] prefix;
    len_e               length;
    logic [CatW-1:0]    category;
    logic [SpecW-1:0]   specificity;
  } entry_t;

  // Table write broadcast to every cell
  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] slot;
    entry_t           entry;
  } wr_t;

  // Lookup probe handed from cell to cell
  typedef struct packed {
    logic [MacW-1:0]  mac;
    logic             hit;
    logic [CatW-1:0]  category;
    logic [SpecW-1:0] specificity;
  } probe_t;

  // Does the address fall inside the entry's assignment?
  function automatic logic entry_covers(entry_t e, logic [MacW-1:0] mac);
    logic oui_eq;
    logic nib_eq;
    logic low_eq;
    logic res;
    oui_eq = (mac[47:24] == e.prefix[35:12]);
    nib_eq = (mac[23:20] == e.prefix[11:8]);
    low_eq = (mac[19:12] == e.prefix[7:0]);
    case (e.length)
      LEN_24:  res = oui_eq;
      LEN_28:  res = oui_eq & nib_eq;
      LEN_36:  res = oui_eq & nib_eq & low_eq;
      default: res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/mptm_cell.sv =====
module mptm_cell #(
  parameter int BASE          = 0,
  parameter int CELL_ENTRIES  = 8,
  parameter int TABLE_ENTRIES = 64,
  parameter int IDX_W         = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mptm_pkg::wr_t                 wr_i,
  input  logic [mptm_pkg::CountW-1:0]   count_i,
  input  logic                          in_valid_i,
  input  mptm_pkg::probe_t              in_probe_i,
  input  logic [IDX_W-1:0]              in_idx_i,
  output logic                          out_valid_o,
  output mptm_pkg::probe_t              out_probe_o,
  output logic [IDX_W-1:0]              out_idx_o
);

  mptm_pkg::entry_t entries_q [CELL_ENTRIES];

  logic                       out_valid_q;
  mptm_pkg::probe_t           probe_q, probe_d;
  logic [IDX_W-1:0]           idx_q, idx_d;

  // Store a load into the local slot it addresses
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < CELL_ENTRIES; k++) begin
      if (wr_i.en && (BASE + k < TABLE_ENTRIES) && (int'(wr_i.slot) == BASE + k)) begin
        entries_q[k] <= wr_i.entry;
      end
    end
  end

  // Pick the lowest local match, unless an earlier cell already hit
  always_comb begin
    probe_d = in_probe_i;
    idx_d   = in_idx_i;
    if (!in_probe_i.hit) begin
      for (int k = CELL_ENTRIES - 1; k >= 0; k--) begin
        if ((BASE + k < TABLE_ENTRIES) && (BASE + k < int'(count_i)) &&
            mptm_pkg::entry_covers(entries_q[k], in_probe_i.mac)) begin
          probe_d.hit         = 1'b1;
          probe_d.category    = entries_q[k].category;
          probe_d.specificity = entries_q[k].specificity;
          idx_d               = IDX_W'(BASE + k);
        end
      end
    end
  end

  // Advance the probe to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      probe_q <= probe_d;
      idx_q   <= idx_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_probe_o = probe_q;
  assign out_idx_o   = idx_q;

endmodule

// ===== rtl/mac_prefix_table_match_unit.sv =====
// MAC prefix table lookup. The table lives in a row of cells, each holding
// CELL_ENTRIES entries (8 by default, so 8 cells for 64 entries). A load request
// writes one entry. A lookup request enters the first cell and moves one cell per
// clock, each cell comparing the address against all of its entries at once and
// keeping the lowest-indexed hit. After the last cell the probe lands in the
// result holding register and then in the output register; the next request is
// taken only once the result has left the holding register. One lookup is in the
// row at a time. A new request is taken while a finished result waits in the
// output register; a second finished result held behind it in the holding
// register stalls the input. Only entries below entry_count (saturated at
// TABLE_ENTRIES) take part; loads to slots at or above TABLE_ENTRIES are dropped.
// The table has no reset, so every entry below entry_count must be loaded before
// a lookup.
module mac_prefix_table_match_unit #(
  parameter int TABLE_ENTRIES = 64,
  parameter int CELL_ENTRIES  = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Register write: entry_count
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mptm_pkg::CountW-1:0]     cfg_data_i,
  // Requests
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // mac_address[47:0], entry_index[53:48], entry_prefix[89:54],
  // entry_length[91:90], entry_category[95:92], entry_specificity[97:96], zero[103:98]
  input  logic [mptm_pkg::InDataW-1:0]    s_axis_tdata_i,
  // kind[0]
  input  logic                            s_axis_tuser_i,
  // Results
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // hit[0], match_index[6:1], match_category[10:7], match_specificity[12:11],
  // zero[15:13]
  output logic [mptm_pkg::OutDataW-1:0]   m_axis_tdata_o
);

  localparam int NumCells = (TABLE_ENTRIES + CELL_ENTRIES - 1) / CELL_ENTRIES;
  localparam int IdxW     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [mptm_pkg::CountW-1:0] count_q;
  logic                        inflight_q;
  logic                        pend_valid_q;
  mptm_pkg::probe_t            pend_probe_q;
  logic [IdxW-1:0]             pend_idx_q;
  logic                        m_valid_q;
  logic [mptm_pkg::OutDataW-1:0] m_data_q, m_data_d;

  logic                        req_accept;
  logic                        lookup_go;
  logic                        pend_move;
  mptm_pkg::wr_t               wr;

  logic [NumCells:0]           chain_valid;
  mptm_pkg::probe_t            chain_probe [NumCells+1];
  logic [IdxW-1:0]             chain_idx   [NumCells+1];

  // Register write port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  // Accept a request only with the row and the holding register empty
  assign s_axis_tready_o = !inflight_q && !pend_valid_q;
  assign req_accept      = s_axis_tvalid_i && s_axis_tready_o;
  assign lookup_go       = req_accept &&
                           (mptm_pkg::kind_e'(s_axis_tuser_i) == mptm_pkg::KIND_LOOKUP);

  // Broadcast a load to the cells
  always_comb begin
    wr.en                = req_accept &&
                           (mptm_pkg::kind_e'(s_axis_tuser_i) == mptm_pkg::KIND_LOAD);
    wr.slot              = s_axis_tdata_i[53:48];
    wr.entry.prefix      = s_axis_tdata_i[89:54];
    wr.entry.length      = mptm_pkg::len_e'(s_axis_tdata_i[91:90]);
    wr.entry.category    = s_axis_tdata_i[95:92];
    wr.entry.specificity = s_axis_tdata_i[97:96];
  end

  // Launch a fresh probe into the first cell
  always_comb begin
    chain_valid[0]             = lookup_go;
    chain_probe[0].mac         = s_axis_tdata_i[47:0];
    chain_probe[0].hit         = 1'b0;
    chain_probe[0].category    = '0;
    chain_probe[0].specificity = '0;
    chain_idx[0]               = '0;
  end

  for (genvar c = 0; c < NumCells; c++) begin : g_cell
    mptm_cell #(
      .BASE          (c * CELL_ENTRIES),
      .CELL_ENTRIES  (CELL_ENTRIES),
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IdxW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .wr_i        (wr),
      .count_i     (count_q),
      .in_valid_i  (chain_valid[c]),
      .in_probe_i  (chain_probe[c]),
      .in_idx_i    (chain_idx[c]),
      .out_valid_o (chain_valid[c+1]),
      .out_probe_o (chain_probe[c+1]),
      .out_idx_o   (chain_idx[c+1])
    );
  end

  // Track the lookup in flight and hold its result until the output frees up
  assign pend_move = pend_valid_q && (!m_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      if (lookup_go) begin
        inflight_q <= 1'b1;
      end else if (chain_valid[NumCells]) begin
        inflight_q <= 1'b0;
      end
      if (chain_valid[NumCells]) begin
        pend_valid_q <= 1'b1;
      end else if (pend_move) begin
        pend_valid_q <= 1'b0;
      end
      if (pend_move) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_valid[NumCells]) begin
      pend_probe_q <= chain_probe[NumCells];
      pend_idx_q   <= chain_idx[NumCells];
    end
  end

  // Pack the result
  always_comb begin
    m_data_d        = '0;
    m_data_d[0]     = pend_probe_q.hit;
    m_data_d[6:1]   = mptm_pkg::MatchIdxW'(pend_idx_q);
    m_data_d[10:7]  = pend_probe_q.category;
    m_data_d[12:11] = pend_probe_q.specificity;
  end

  always_ff @(posedge clk_i) begin
    if (pend_move) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // At most one probe travels the row
  a_one_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(chain_valid[NumCells:1]) <= 1)
    else $error("more than one probe in the cell row");

  // A probe leaves the row only for a lookup in flight, into an empty holding register
  a_exit_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_valid[NumCells] |-> (inflight_q && !pend_valid_q))
    else $error("probe left the row without a lookup in flight");

  // An accepted lookup is in the row on the next cycle
  a_lookup_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lookup_go |=> (inflight_q && (chain_valid[NumCells:1] != '0)))
    else $error("accepted lookup not tracked");

  // A miss reports zero index, category and specificity
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_data_q[0]) |-> (m_data_q[12:1] == '0))
    else $error("miss result carries nonzero fields");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import mptm_pkg::*;

  localparam int Slots        = 64;
  localparam int SettleCycles = 16;
  localparam int HoldCycles   = 400;
  localparam int IdleLimit    = 5000;
  localparam int MaxReports   = 40;

  typedef struct {
    logic                 hit;
    logic [MatchIdxW-1:0] index;
    logic [CatW-1:0]      category;
    logic [SpecW-1:0]     specificity;
  } lookup_result_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CountW-1:0]     cfg_data_i      = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [InDataW-1:0]    s_axis_tdata_i  = '0;
  logic                  s_axis_tuser_i  = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata_o;

  // Shadow of the table and the entry count register
  entry_t                prefix_slots [Slots];
  logic                  slot_loaded [Slots];
  logic [CountW-1:0]     entry_count_q = '0;
  lookup_result_t        expected_results [$];
  logic [23:0]           oui_pool [4];

  int  errors        = 0;
  int  n_checked     = 0;
  int  n_lookups     = 0;
  int  n_hits        = 0;
  int  n_loads       = 0;
  int  n_cfg         = 0;
  int  idle_cycles   = 0;
  int  hold_requests = 0;
  int  hold_taken    = 0;
  int  hold_left     = 0;
  int  rx_gap_left   = 0;
  int  rx_mode_left  = 0;
  bit  rx_steady     = 1'b0;
  bit  tx_steady     = 1'b0;

  mac_prefix_table_match_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Prefix comparison at the entry's length; code three never matches
  function automatic logic address_in_block(entry_t e, logic [MacW-1:0] mac);
    logic [PrefixW-1:0] top;
    top = mac[47:12];
    case (e.length)
      LEN_24:  return top[35:12] == e.prefix[35:12];
      LEN_28:  return top[35:8] == e.prefix[35:8];
      LEN_36:  return top == e.prefix;
      default: return 1'b0;
    endcase
  endfunction

  function automatic int considered_entries();
    return (entry_count_q > Slots) ? Slots : int'(entry_count_q);
  endfunction

  // First entry below the count that holds the address
  function automatic lookup_result_t classify_address(logic [MacW-1:0] mac);
    lookup_result_t r;
    int limit;
    r = '{1'b0, '0, '0, '0};
    limit = considered_entries();
    for (int i = 0; i < limit; i++) begin
      if (address_in_block(prefix_slots[i], mac)) begin
        r.hit         = 1'b1;
        r.index       = MatchIdxW'(i);
        r.category    = prefix_slots[i].category;
        r.specificity = prefix_slots[i].specificity;
        return r;
      end
    end
    return r;
  endfunction

  function automatic logic [MacW-1:0] random_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Entries drawn from a few shared blocks so that several entries overlap
  function automatic entry_t random_entry();
    entry_t e;
    e.prefix[35:12] = ($urandom_range(0, 4) != 0) ? oui_pool[$urandom_range(0, 3)]
                                                   : 24'($urandom);
    e.prefix[11:8]  = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 1)) : 4'($urandom);
    e.prefix[7:0]   = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
    e.length        = len_e'($urandom_range(0, 3));
    e.category      = 4'($urandom);
    e.specificity   = 2'($urandom);
    return e;
  endfunction

  // Address near a considered entry, sometimes with one bit flipped in a chosen part; now and then a random address
  function automatic logic [MacW-1:0] pick_address();
    logic [MacW-1:0] mac;
    int limit;
    int b;
    mac = random_mac();
    limit = considered_entries();
    if (limit == 0 || $urandom_range(0, 9) < 2) begin
      if ($urandom_range(0, 1) != 0) mac[47:24] = oui_pool[$urandom_range(0, 3)];
      return mac;
    end
    mac[47:12] = prefix_slots[$urandom_range(0, limit - 1)].prefix;
    case ($urandom_range(0, 3))
      1:       b = 12 + $urandom_range(0, 7);
      2:       b = 20 + $urandom_range(0, 3);
      3:       b = 24 + $urandom_range(0, 23);
      default: b = -1;
    endcase
    if (b >= 0) mac[b] = ~mac[b];
    return mac;
  endfunction

  // Highest count whose entries have all been loaded
  function automatic int safe_count();
    for (int i = 0; i < Slots; i++) begin
      if (!slot_loaded[i]) return i;
    end
    return Slots;
  endfunction

  function automatic int choose_count();
    int safe;
    int pick;
    safe = safe_count();
    pick = $urandom_range(0, 5);
    if (pick == 0 || safe == 0) return 0;
    if (pick == 1) return safe;
    if (safe == Slots && pick == 2) return 127;
    if (safe == Slots && pick == 3) return $urandom_range(Slots + 1, 127);
    return $urandom_range(1, safe);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    if (errors <= MaxReports) begin
      $display("%0t result %0d: %s mismatch, got %0h want %0h", $time, n_checked, what,
               got, want);
    end
  endtask

  // Drop valid for a gap whose length is set by n
  task automatic tx_pause(int n);
    if (n > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Offer one request, hold until taken, then update the shadow table
  task automatic send_request(kind_e kind, logic [MacW-1:0] mac, logic [SlotW-1:0] slot,
                              entry_t e);
    lookup_result_t r;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = kind;
    s_axis_tdata_i  = {6'd0, e.specificity, e.category, e.length, e.prefix, slot, mac};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (kind == KIND_LOAD) begin
      prefix_slots[slot] = e;
      slot_loaded[slot]  = 1'b1;
      n_loads++;
    end else begin
      r = classify_address(mac);
      expected_results.push_back(r);
      n_lookups++;
      if (r.hit) n_hits++;
    end
    tx_pause(pick_gap(tx_steady));
  endtask

  task automatic send_lookup(logic [MacW-1:0] mac);
    send_request(KIND_LOOKUP, mac, SlotW'($urandom), random_entry());
  endtask

  task automatic send_load(int slot, entry_t e);
    send_request(KIND_LOAD, random_mac(), SlotW'(slot), e);
  endtask

  // Wait until every lookup has returned and the block has gone quiet
  task automatic settle_block();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_entry_count(int value);
    settle_block();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = CountW'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    entry_count_q = CountW'(value);
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Count zero: nothing is considered
  task automatic test_empty_table();
    send_lookup('0);
    send_lookup('1);
  endtask

  // One block at every length, behind an entry that never matches
  task automatic test_length_codes();
    logic [PrefixW-1:0] p;
    p = 36'h5A3C7E91B;
    send_load(0, '{prefix: p, length: LEN_NONE, category: 4'd1, specificity: 2'd0});
    send_load(1, '{prefix: p, length: LEN_36, category: 4'd2, specificity: 2'd1});
    send_load(2, '{prefix: p, length: LEN_28, category: 4'd3, specificity: 2'd2});
    send_load(3, '{prefix: p, length: LEN_24, category: 4'd4, specificity: 2'd3});
    send_load(4, '{prefix: '0, length: LEN_36, category: 4'd0, specificity: 2'd0});
    send_load(5, '{prefix: '1, length: LEN_36, category: 4'd15, specificity: 2'd3});
    set_entry_count(6);
    send_lookup({p, 12'hABC});
    send_lookup({p ^ 36'h000000001, 12'h000});
    send_lookup({p ^ 36'h000000100, 12'hFFF});
    send_lookup({p ^ 36'h800000000, 12'h123});
    send_lookup('0);
    send_lookup('1);
    // Only the never-matching entry is considered
    set_entry_count(1);
    send_lookup({p, 12'h000});
  endtask

  // Load every remaining slot in random order, lookups mixed in
  task automatic test_fill_table();
    int order [$];
    int j;
    int t;
    set_entry_count(6);
    for (int s = 0; s < Slots; s++) begin
      if (!slot_loaded[s]) order.push_back(s);
    end
    for (int i = order.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    foreach (order[i]) begin
      send_load(order[i], random_entry());
      if ($urandom_range(0, 1) != 0) send_lookup(pick_address());
    end
  endtask

  // Phases at random counts, loads rewriting entries between lookups
  task automatic test_random_traffic(int phases);
    repeat (phases) begin
      set_entry_count(choose_count());
      tx_steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(30, 70)) begin
        if ($urandom_range(0, 3) == 0) send_load($urandom_range(0, Slots - 1), random_entry());
        else send_lookup(pick_address());
      end
    end
    tx_steady = 1'b0;
  endtask

  // Hold results back long enough for the input side to stall
  task automatic test_backpressure();
    set_entry_count(Slots);
    hold_requests++;
    tx_steady = 1'b1;
    repeat (40) send_lookup(pick_address());
    tx_steady = 1'b0;
    settle_block();
  endtask

  // Result side: random stalls, steady stretches and requested long holds
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i = 1'b0;
    end else begin
      if (hold_taken != hold_requests) begin
        hold_taken = hold_requests;
        hold_left  = HoldCycles;
      end
      if (rx_mode_left == 0) begin
        rx_steady    = ($urandom_range(0, 3) == 0);
        rx_mode_left = $urandom_range(20, 200);
      end else begin
        rx_mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i = 1'b0;
      end else if (rx_gap_left > 0) begin
        rx_gap_left--;
        m_axis_tready_i = 1'b0;
      end else begin
        m_axis_tready_i = 1'b1;
        if (!rx_steady && $urandom_range(0, 4) == 0) rx_gap_left = pick_gap(1'b0);
      end
    end
  end

  // Compare each accepted result with the oldest pending lookup
  always @(posedge clk_i) begin : check_results
    lookup_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_checked++;
      if (expected_results.size() == 0) begin
        report_mismatch("unrequested result", m_axis_tdata_o, 0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata_o[0] !== want.hit)
          report_mismatch("hit", m_axis_tdata_o[0], want.hit);
        if (m_axis_tdata_o[6:1] !== want.index)
          report_mismatch("match_index", m_axis_tdata_o[6:1], want.index);
        if (m_axis_tdata_o[10:7] !== want.category)
          report_mismatch("match_category", m_axis_tdata_o[10:7], want.category);
        if (m_axis_tdata_o[12:11] !== want.specificity)
          report_mismatch("match_specificity", m_axis_tdata_o[12:11], want.specificity);
      end
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("mac_prefix_table_match_unit regression: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < Slots; i++) begin
      prefix_slots[i] = '0;
      slot_loaded[i]  = 1'b0;
    end
    for (int i = 0; i < 4; i++) oui_pool[i] = 24'($urandom);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_table();
    test_length_codes();
    test_fill_table();
    test_random_traffic(11);
    test_backpressure();
    settle_block();

    $display("covered %0d lookups (%0d hits) and %0d loads over %0d entry_count settings",
             n_lookups, n_hits, n_loads, n_cfg);
    $display("checked %0d results, %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("mac_prefix_table_match_unit regression: pass");
    end else begin
      $display("mac_prefix_table_match_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mptm_pkg.sv
rtl/mptm_cell.sv
rtl/mac_prefix_table_match_unit.sv
sim/testbench.sv
